// ===== hdl/assert_macros.svh =====
// shared assertion macros for the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/anpp_pkg.sv =====
// ----------------------------------------------------------------------------
// anpp_pkg
// Constants, record type and identifier table for the Art-Net packet parser.
// ----------------------------------------------------------------------------
package anpp_pkg;

    localparam int BUFFER_BYTES_DEF = 1024;

    localparam logic [15:0] OP_POLL = 16'h2000;
    localparam logic [15:0] OP_DMX  = 16'h5000;

    // byte offsets within the udp payload
    localparam int ID_LEN       = 8;
    localparam int POS_OP_LO    = 8;
    localparam int POS_OP_HI    = 9;
    localparam int POS_SEQ      = 12;
    localparam int POS_UNIV_LO  = 14;
    localparam int POS_UNIV_HI  = 15;
    localparam int POS_LEN_HI   = 16;
    localparam int POS_LEN_LO   = 17;
    localparam int DATA_OFFSET  = 18;
    localparam int MIN_HEADER   = 10;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_POLL = 2'd2;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  channel_byte;
        logic [9:0]  channel_index;
        logic [9:0]  data_count;
        logic [15:0] universe;
        logic [7:0]  sequence_res;
        logic [31:0] source_ip;
        logic [15:0] source_port;
    } t_result;

    // "Art-Net" followed by a zero byte
    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h41;
            3'd1:    v = 8'h72;
            3'd2:    v = 8'h74;
            3'd3:    v = 8'h2d;
            3'd4:    v = 8'h4e;
            3'd5:    v = 8'h65;
            3'd6:    v = 8'h74;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/artnet_packet_parser_unit.sv =====
// ----------------------------------------------------------------------------
// artnet_packet_parser_unit
// Parses Art-Net udp payload bytes: checks the identifier and opcode, passes
// on ArtDmx slot bytes with an end record, and flags ArtPoll requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   data_byte, last_byte, sender ip/port
//  result    out        o_valid / i_stall   kind, slot byte/index, count, header
//
//  one byte is taken per cycle while o_stall is low; its records pass from the
//  input register into the result queue and appear at the outputs from there.
//  a byte can give two records (last slot byte plus end record), so the
//  eight-entry result queue sets the input stall when it could overflow.
//  reset empties the queue and returns the parser to the packet start.
//  with the result side stalled, the queue fills and the input stalls before
//  it can overflow; nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module artnet_packet_parser_unit #(
    parameter int BUFFER_BYTES = anpp_pkg::BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_sender_ip,
    input  logic [15:0] i_sender_port,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_channel_byte,
    output logic [9:0]  o_channel_index,
    output logic [9:0]  o_data_count,
    output logic [15:0] o_universe,
    output logic [7:0]  o_sequence_res,
    output logic [31:0] o_source_ip,
    output logic [15:0] o_source_port
);

    localparam int POS_W = $clog2(BUFFER_BYTES + 1);
    localparam int PTR_W = anpp_pkg::PTR_W;
    localparam int CNT_W = anpp_pkg::CNT_W;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [31:0] r_in_ip;
    logic [15:0] r_in_port;

    // parser state
    logic [POS_W-1:0] r_pos,  n_pos;
    logic             r_id,   n_id;
    logic [15:0]      r_op,   n_op;
    logic [7:0]       r_seq,  n_seq;
    logic [15:0]      r_univ, n_univ;
    logic [15:0]      r_len,  n_len;
    logic [POS_W-1:0] r_emit, n_emit;

    // result queue
    anpp_pkg::t_result r_fifo [anpp_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic             in_accept;
    logic             out_accept;
    logic             in_buf;
    logic [POS_W-1:0] slot;
    logic             dmx_hit;
    logic             end_hit;
    logic             poll_hit;
    logic [1:0]       n_push;
    anpp_pkg::t_result rec_data, rec_tail;
    anpp_pkg::t_result head;

    assign in_accept  = i_valid && !o_stall;
    assign out_accept = o_valid && !i_stall;

    // worst case two records for the item in the input register
    assign o_stall = (5'(r_count) + (r_in_valid ? 5'd2 : 5'd0))
                     > 5'(anpp_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept;
        end
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
            r_in_ip   <= i_sender_ip;
            r_in_port <= i_sender_port;
        end
    end

    assign in_buf = r_pos < POS_W'(BUFFER_BYTES);
    assign slot   = r_pos - POS_W'(anpp_pkg::DATA_OFFSET);

    always_comb begin
        n_pos   = r_pos;
        n_id    = r_id;
        n_op    = r_op;
        n_seq   = r_seq;
        n_univ  = r_univ;
        n_len   = r_len;
        n_emit  = r_emit;
        dmx_hit = 1'b0;
        if (r_in_valid && in_buf) begin
            if (r_pos < POS_W'(anpp_pkg::ID_LEN)) begin
                if (r_in_byte != anpp_pkg::id_byte(r_pos[2:0])) begin
                    n_id = 1'b0;
                end
            end else if (r_pos == POS_W'(anpp_pkg::POS_OP_LO)) begin
                n_op = {8'h00, r_in_byte};
            end else if (r_pos == POS_W'(anpp_pkg::POS_OP_HI)) begin
                n_op = {r_in_byte, r_op[7:0]};
            end else if (r_pos == POS_W'(anpp_pkg::POS_SEQ)) begin
                n_seq = r_in_byte;
            end else if (r_pos == POS_W'(anpp_pkg::POS_UNIV_LO)) begin
                n_univ = {8'h00, r_in_byte};
            end else if (r_pos == POS_W'(anpp_pkg::POS_UNIV_HI)) begin
                n_univ = {r_in_byte, r_univ[7:0]};
            end else if (r_pos == POS_W'(anpp_pkg::POS_LEN_HI)) begin
                n_len = {r_in_byte, 8'h00};
            end else if (r_pos == POS_W'(anpp_pkg::POS_LEN_LO)) begin
                n_len = {r_len[15:8], r_in_byte};
            end else if (r_pos >= POS_W'(anpp_pkg::DATA_OFFSET)) begin
                if (r_id && r_op == anpp_pkg::OP_DMX && 16'(slot) < r_len) begin
                    dmx_hit = 1'b1;
                    n_emit  = r_emit + POS_W'(1);
                end
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    // packet end decisions use the state after this byte
    always_comb begin
        end_hit  = 1'b0;
        poll_hit = 1'b0;
        if (r_in_valid && r_in_last && n_pos >= POS_W'(anpp_pkg::MIN_HEADER) && n_id) begin
            if (n_op == anpp_pkg::OP_POLL) begin
                poll_hit = 1'b1;
            end else if (n_op == anpp_pkg::OP_DMX
                         && n_pos >= POS_W'(anpp_pkg::DATA_OFFSET)) begin
                end_hit = 1'b1;
            end
        end
    end

    always_comb begin
        rec_data               = '0;
        rec_data.kind          = anpp_pkg::KIND_DATA;
        rec_data.channel_byte  = r_in_byte;
        rec_data.channel_index = 10'(slot);
        rec_data.universe      = n_univ;
        rec_data.sequence_res  = n_seq;
        rec_data.source_ip     = r_in_ip;
        rec_data.source_port   = r_in_port;

        rec_tail             = '0;
        rec_tail.source_ip   = r_in_ip;
        rec_tail.source_port = r_in_port;
        if (poll_hit) begin
            rec_tail.kind = anpp_pkg::KIND_POLL;
        end else begin
            rec_tail.kind         = anpp_pkg::KIND_END;
            rec_tail.data_count   = 10'(n_emit);
            rec_tail.universe     = n_univ;
            rec_tail.sequence_res = n_seq;
        end
    end

    assign n_push = 2'(dmx_hit) + 2'(end_hit || poll_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_in_valid && r_in_last)) begin
            r_pos  <= '0;
            r_id   <= 1'b1;
            r_op   <= '0;
            r_seq  <= '0;
            r_univ <= '0;
            r_len  <= '0;
            r_emit <= '0;
        end else begin
            r_pos  <= n_pos;
            r_id   <= n_id;
            r_op   <= n_op;
            r_seq  <= n_seq;
            r_univ <= n_univ;
            r_len  <= n_len;
            r_emit <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dmx_hit) begin
            r_fifo[r_wr_ptr] <= rec_data;
            if (end_hit || poll_hit) begin
                r_fifo[r_wr_ptr + PTR_W'(1)] <= rec_tail;
            end
        end else if (end_hit || poll_hit) begin
            r_fifo[r_wr_ptr] <= rec_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(n_push);
            r_rd_ptr <= r_rd_ptr + PTR_W'(out_accept);
            r_count  <= r_count + CNT_W'(n_push) - CNT_W'(out_accept);
        end
    end

    assign head            = r_fifo[r_rd_ptr];
    assign o_valid         = r_count != '0;
    assign o_kind          = head.kind;
    assign o_channel_byte  = head.channel_byte;
    assign o_channel_index = head.channel_index;
    assign o_data_count    = head.data_count;
    assign o_universe      = head.universe;
    assign o_sequence_res  = head.sequence_res;
    assign o_source_ip     = head.source_ip;
    assign o_source_port   = head.source_port;

    `ASSERT_NEVER(a_fifo_bound, i_clk, i_rst_n, r_count > CNT_W'(anpp_pkg::FIFO_DEPTH))
    `ASSERT_NEVER(a_pos_bound, i_clk, i_rst_n, r_pos > POS_W'(BUFFER_BYTES))
    `ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, r_in_valid && r_in_last, r_pos == '0 && r_id)
    `ASSERT_NEVER(a_emit_le_pos, i_clk, i_rst_n, r_emit > r_pos)

endmodule
